### design/nqfs_pkg.sv
`default_nettype none

package nqfs_pkg;

	// board limits
	localparam int unsigned MAX_N     = 16;
	localparam int unsigned SIZE_W    = 5;
	localparam int unsigned ROW_IDX_W = 4;
	localparam int unsigned DIAG_BITS = 2 * MAX_N - 1;

	// one result item
	typedef struct packed {
		logic              found;
		logic [MAX_N-1:0]  row_bits;
		logic              last_row;
	} res_t;

endpackage : nqfs_pkg

`default_nettype wire

### design/nqfs_engine.sv
`default_nettype none

module nqfs_engine
	import nqfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start_go,
	input  wire logic [SIZE_W-1:0] start_size,
	output logic                   idle,
	output logic                   res_valid,
	output res_t                   res,
	input  wire logic              res_ready
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_PLACE    = 7'b0000010,
		S_BACK     = 7'b0000100,
		S_EMIT_RD  = 7'b0001000,
		S_EMIT_ACC = 7'b0010000,
		S_EMIT_OUT = 7'b0100000,
		S_FAIL_OUT = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [SIZE_W-1:0]      n_q;
	logic [SIZE_W-1:0]      col_q;
	logic [SIZE_W-1:0]      start_q;
	logic [MAX_N-1:0]       rows_q;
	logic [DIAG_BITS-1:0]   down_q;
	logic [DIAG_BITS-1:0]   up_q;
	logic [ROW_IDX_W-1:0]   erow_q;
	logic [ROW_IDX_W-1:0]   ecol_q;
	logic [MAX_N-1:0]       bits_q;

	// column -> row memory
	logic [ROW_IDX_W-1:0]   col_mem [MAX_N];
	logic                   wr_en;
	logic [ROW_IDX_W-1:0]   wr_addr;
	logic [ROW_IDX_W-1:0]   wr_data;
	logic                   rd_en;
	logic [ROW_IDX_W-1:0]   rd_addr;
	logic [ROW_IDX_W-1:0]   rd_data_q;

	logic [SIZE_W-1:0]      n_sat;
	logic [ROW_IDX_W-1:0]   c_idx;
	logic [ROW_IDX_W-1:0]   d_shift;
	logic [MAX_N-1:0]       dsel;
	logic [MAX_N-1:0]       usel;
	logic [MAX_N-1:0]       range_mask;
	logic [MAX_N-1:0]       free_rows;
	logic                   any_free;
	logic [ROW_IDX_W-1:0]   pick;
	logic [SIZE_W-1:0]      pick_d_idx;
	logic [SIZE_W-1:0]      pick_u_idx;
	logic [SIZE_W-1:0]      back_d_idx;
	logic [SIZE_W-1:0]      back_u_idx;
	logic                   col_done;
	logic                   ecol_last;
	logic                   erow_last;

	always_comb begin
		if (start_size == '0) begin
			n_sat = SIZE_W'(1);
		end else if (start_size > SIZE_W'(MAX_N)) begin
			n_sat = SIZE_W'(MAX_N);
		end else begin
			n_sat = start_size;
		end
	end

	// free row search for the current column
	assign c_idx      = col_q[ROW_IDX_W-1:0];
	assign d_shift    = ROW_IDX_W'(MAX_N - 1) - c_idx;
	assign dsel       = MAX_N'(down_q >> d_shift);
	assign usel       = MAX_N'(up_q >> c_idx);
	assign range_mask = ({MAX_N{1'b1}} << start_q) & ~({MAX_N{1'b1}} << n_q);
	assign free_rows  = range_mask & ~rows_q & ~dsel & ~usel;
	assign any_free   = |free_rows;
	assign col_done   = (col_q >= n_q);

	always_comb begin
		pick = '0;
		for (int i = MAX_N - 1; i >= 0; i--) begin
			if (free_rows[i]) begin
				pick = ROW_IDX_W'(i);
			end
		end
	end

	assign pick_d_idx = {1'b0, pick} + SIZE_W'(MAX_N - 1) - {1'b0, c_idx};
	assign pick_u_idx = {1'b0, pick} + {1'b0, c_idx};
	assign back_d_idx = {1'b0, rd_data_q} + SIZE_W'(MAX_N - 1) - {1'b0, c_idx};
	assign back_u_idx = {1'b0, rd_data_q} + {1'b0, c_idx};

	assign ecol_last = (({1'b0, ecol_q} + SIZE_W'(1)) == n_q);
	assign erow_last = (({1'b0, erow_q} + SIZE_W'(1)) == n_q);

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = c_idx;
		wr_data = pick;
		rd_en   = 1'b0;
		rd_addr = ecol_q;
		if (state_q == S_PLACE && !col_done) begin
			if (any_free) begin
				wr_en = 1'b1;
			end else if (col_q != '0) begin
				rd_en   = 1'b1;
				rd_addr = c_idx - ROW_IDX_W'(1);
			end
		end else if (state_q == S_EMIT_RD) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			col_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= col_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			col_q   <= '0;
			start_q <= '0;
			rows_q  <= '0;
			down_q  <= '0;
			up_q    <= '0;
			erow_q  <= '0;
			ecol_q  <= '0;
			bits_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_go) begin
						n_q     <= n_sat;
						col_q   <= '0;
						start_q <= '0;
						rows_q  <= '0;
						down_q  <= '0;
						up_q    <= '0;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (col_done) begin
						erow_q  <= '0;
						ecol_q  <= '0;
						bits_q  <= '0;
						state_q <= S_EMIT_RD;
					end else if (any_free) begin
						rows_q  <= rows_q | (MAX_N'(1) << pick);
						down_q  <= down_q | (DIAG_BITS'(1) << pick_d_idx);
						up_q    <= up_q | (DIAG_BITS'(1) << pick_u_idx);
						col_q   <= col_q + SIZE_W'(1);
						start_q <= '0;
					end else if (col_q == '0) begin
						state_q <= S_FAIL_OUT;
					end else begin
						col_q   <= col_q - SIZE_W'(1);
						state_q <= S_BACK;
					end
				end
				S_BACK: begin
					// lift the queen of the previous column, retry above it
					rows_q  <= rows_q & ~(MAX_N'(1) << rd_data_q);
					down_q  <= down_q & ~(DIAG_BITS'(1) << back_d_idx);
					up_q    <= up_q & ~(DIAG_BITS'(1) << back_u_idx);
					start_q <= {1'b0, rd_data_q} + SIZE_W'(1);
					state_q <= S_PLACE;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_ACC;
				end
				S_EMIT_ACC: begin
					if (rd_data_q == erow_q) begin
						bits_q <= bits_q | (MAX_N'(1) << ecol_q);
					end
					if (ecol_last) begin
						state_q <= S_EMIT_OUT;
					end else begin
						ecol_q  <= ecol_q + ROW_IDX_W'(1);
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_OUT: begin
					if (res_ready) begin
						if (erow_last) begin
							state_q <= S_IDLE;
						end else begin
							erow_q  <= erow_q + ROW_IDX_W'(1);
							ecol_q  <= '0;
							bits_q  <= '0;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_FAIL_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT_OUT) || (state_q == S_FAIL_OUT);

	always_comb begin
		res.found    = (state_q == S_EMIT_OUT);
		res.row_bits = (state_q == S_EMIT_OUT) ? bits_q : '0;
		res.last_row = (state_q == S_FAIL_OUT) || erow_last;
	end

	// one queen per placed column, each on its own row and diagonals
	a_rows_match_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |-> $countones(rows_q) == col_q)
		else $error("row mask count differs from column count");

	a_diags_match_rows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |->
			($countones(down_q) == $countones(rows_q)) &&
			($countones(up_q) == $countones(rows_q)))
		else $error("diagonal masks out of step with row mask");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.last_row && res.row_bits == '0)
		else $error("failure item must be a single empty last item");

	a_start_enters_search: assert property (@(posedge clk) disable iff (!arst_n)
		idle && start_go |=> state_q == S_PLACE && col_q == '0 && rows_q == '0)
		else $error("search did not start from a clear board");

endmodule : nqfs_engine

`default_nettype wire

### design/nqfs_out_reg.sv
`default_nettype none

module nqfs_out_reg
	import nqfs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire res_t in_data,
	output logic      in_ready,
	output logic      out_valid,
	output res_t      out_data,
	input  wire logic out_stall
);

	logic valid_q;
	res_t data_q;

	assign in_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule : nqfs_out_reg

`default_nettype wire

### design/n_queens_first_solution_core.sv
// first n-queens placement by depth-first backtracking, one search at a time
// steps: place one queen per column, or on a dead end read back the previous column and lift its queen;
// then each row item is built column by column from the column memory and handed to the output register
// throughput: one search in flight; start_stall is high until its last item enters the output register
// search time is set by the backtrack loop over the column memory (one access a cycle)
// reset: arst_n clears the controller, masks and output valid; column memory is not cleared
`default_nettype none

module n_queens_first_solution_core
	import nqfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start_valid,
	output logic                   start_stall,
	input  wire logic [SIZE_W-1:0] board_size,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   found,
	output logic [MAX_N-1:0]       row_bits,
	output logic                   last_row
);

	logic engine_idle;
	logic start_go;
	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_item;

	// a new board size is taken only while the engine has no search running
	assign start_stall = !engine_idle;
	assign start_go    = start_valid && engine_idle;

	// search engine: masks in registers, chosen rows in a synchronous column memory
	nqfs_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_go   (start_go),
		.start_size (board_size),
		.idle       (engine_idle),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	// output register decouples the engine from result_stall
	nqfs_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.in_ready  (res_ready),
		.out_valid (result_valid),
		.out_data  (out_item),
		.out_stall (result_stall)
	);

	assign found    = out_item.found;
	assign row_bits = out_item.row_bits;
	assign last_row = out_item.last_row;

endmodule : n_queens_first_solution_core

`default_nettype wire

### tb/n_queens_first_solution_core_tb.sv
`timescale 1ns / 1ps

module n_queens_first_solution_core_tb;
	import nqfs_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 5;
	// the largest boards backtrack through many thousands of placements
	localparam int IDLE_LIMIT   = 5000000;
	// room for a stray item after the last row
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 4000;
	localparam int RANDOM_ITEMS = 100;
	localparam int MAX_WAIT     = 19;

	// predicts the board rows of each search and checks the rows the block returns
	class queen_placement_check;
		res_t                 expected_rows[$];
		int                   mismatches = 0;
		logic [ROW_IDX_W-1:0] queen_row[MAX_N];

		// depth first, column by column, lowest free row first
		function bit solve_board(int n);
			logic [MAX_N-1:0]     rows_used;
			logic [DIAG_BITS-1:0] down_used;
			logic [DIAG_BITS-1:0] up_used;
			int                   col;
			int                   row;
			int                   first_row;
			bit                   placed;
			rows_used = '0;
			down_used = '0;
			up_used   = '0;
			col       = 0;
			first_row = 0;
			forever begin
				if (col >= n)
					return 1'b1;
				placed = 1'b0;
				row    = first_row;
				while (row < n && !placed) begin
					if (!rows_used[row] && !down_used[row - col + MAX_N - 1]
							&& !up_used[row + col])
						placed = 1'b1;
					else
						row++;
				end
				if (placed) begin
					rows_used[row]                 = 1'b1;
					down_used[row - col + MAX_N - 1] = 1'b1;
					up_used[row + col]             = 1'b1;
					queen_row[col] = row[ROW_IDX_W-1:0];
					col++;
					first_row = 0;
				end else begin
					if (col == 0)
						return 1'b0;
					col--;
					row = int'(queen_row[col]);
					rows_used[row]                 = 1'b0;
					down_used[row - col + MAX_N - 1] = 1'b0;
					up_used[row + col]             = 1'b0;
					first_row = row + 1;
				end
			end
		endfunction

		function void note_size(logic [SIZE_W-1:0] size);
			int   n;
			res_t item;
			n = int'(size);
			if (n < 1)
				n = 1;
			if (n > MAX_N)
				n = MAX_N;
			if (!solve_board(n)) begin
				item          = '0;
				item.last_row = 1'b1;
				expected_rows.push_back(item);
				return;
			end
			for (int r = 0; r < n; r++) begin
				item       = '0;
				item.found = 1'b1;
				for (int c = 0; c < n; c++)
					if (int'(queen_row[c]) == r)
						item.row_bits[c] = 1'b1;
				item.last_row = (r == n - 1);
				expected_rows.push_back(item);
			end
		endfunction

		function void check_row(logic got_found, logic [MAX_N-1:0] got_bits, logic got_last);
			res_t want;
			if (expected_rows.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item found=%0b row_bits=%h last_row=%0b",
					$time, got_found, got_bits, got_last);
				return;
			end
			want = expected_rows.pop_front();
			if (got_found !== want.found) begin
				mismatches++;
				$display("%0t: found expected %0b actual %0b", $time, want.found, got_found);
			end
			if (got_bits !== want.row_bits) begin
				mismatches++;
				$display("%0t: row_bits expected %h actual %h", $time, want.row_bits, got_bits);
			end
			if (got_last !== want.last_row) begin
				mismatches++;
				$display("%0t: last_row expected %0b actual %0b", $time, want.last_row, got_last);
			end
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction
	endclass

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start_valid  = 1'b0;
	logic [SIZE_W-1:0] board_size   = '0;
	logic              result_stall = 1'b0;
	logic              start_stall;
	logic              result_valid;
	logic              found;
	logic [MAX_N-1:0]  row_bits;
	logic              last_row;

	queen_placement_check sb = new();

	// set by the stimulus, taken by the receiver at its next decision point
	bit hold_request = 1'b0;
	// sender runs back to back while set, flipped at random
	bit send_calm    = 1'b0;
	int idle_cycles  = 0;

	n_queens_first_solution_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_valid  (start_valid),
		.start_stall  (start_stall),
		.board_size   (board_size),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.row_bits     (row_bits),
		.last_row     (last_row)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// offer one board size after a random gap and hold it until taken
	task automatic send_size(input logic [SIZE_W-1:0] size);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if ($urandom_range(0, 15) == 0)
			send_calm = !send_calm;
		// valid only drops when a gap follows, so no low-high pair lands in one step
		if (gap > 0) begin
			start_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_valid <= 1'b1;
		board_size  <= size;
		do
			@(posedge clk);
		while (start_stall);
		sb.note_size(size);
	endtask

	// at least one edge passes, so a following drive never shares a step with the last one
	task automatic wait_drained();
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// result side: random stall per item, calm stretches, one long hold-off on request
	initial begin
		int stall_cycles;
		bit recv_calm;
		recv_calm = 1'b0;
		forever begin
			if (hold_request) begin
				// block stays busy with its rows, so the sender is pushed back
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall_cycles = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 15) == 0)
					recv_calm = !recv_calm;
				if (stall_cycles > 0) begin
					result_stall <= 1'b1;
					repeat (stall_cycles) @(posedge clk);
				end
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!result_valid);
			sb.check_row(found, row_bits, last_row);
		end
	end

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start_valid && !start_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d rows outstanding",
				$time, idle_cycles, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		// size zero, no-solution boards, small and full boards, over-limit sizes
		logic [SIZE_W-1:0] directed_sizes[14] = '{
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
			5'd7, 5'd8, 5'd10, 5'd15, 5'd16, 5'd31, 5'd9
		};
		logic [SIZE_W-1:0] size;
		int                pick;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_sizes[i])
			send_size(directed_sizes[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// long receiver hold while items keep coming
			if (i == 30)
				hold_request = 1'b1;
			// sender pause until every row is back
			if (i == 60) begin
				start_valid <= 1'b0;
				wait_drained();
			end
			// mostly quick boards, a few slow ones and saturating sizes
			pick = $urandom_range(0, 99);
			if (pick < 82)
				size = SIZE_W'($urandom_range(1, 12));
			else if (pick < 90)
				size = SIZE_W'($urandom_range(13, 15));
			else if (pick < 94)
				size = '0;
			else
				size = SIZE_W'($urandom_range(16, 31));
			send_size(size);
		end

		start_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
